[hdl/cpu8alu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_pkg
// Operation codes, branch selectors, status bit positions, reset values and a
// Z/N flag helper for the 8-bit execute unit.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

    localparam int ModeW = 6;
    localparam int ByteW = 8;

    typedef logic [ModeW-1:0] mode_t;
    typedef logic [ByteW-1:0] byte_t;

    // Operation codes
    localparam mode_t OP_ADC = 6'd0;
    localparam mode_t OP_SBC = 6'd1;
    localparam mode_t OP_AND = 6'd2;
    localparam mode_t OP_ORA = 6'd3;
    localparam mode_t OP_EOR = 6'd4;
    localparam mode_t OP_CMP = 6'd5;
    localparam mode_t OP_CPX = 6'd6;
    localparam mode_t OP_CPY = 6'd7;
    localparam mode_t OP_BIT = 6'd8;
    localparam mode_t OP_ASL = 6'd9;
    localparam mode_t OP_LSR = 6'd10;
    localparam mode_t OP_ROL = 6'd11;
    localparam mode_t OP_ROR = 6'd12;
    localparam mode_t OP_INC = 6'd13;
    localparam mode_t OP_DEC = 6'd14;
    localparam mode_t OP_INX = 6'd15;
    localparam mode_t OP_INY = 6'd16;
    localparam mode_t OP_DEX = 6'd17;
    localparam mode_t OP_DEY = 6'd18;
    localparam mode_t OP_LDA = 6'd19;
    localparam mode_t OP_LDX = 6'd20;
    localparam mode_t OP_LDY = 6'd21;
    localparam mode_t OP_TAX = 6'd22;
    localparam mode_t OP_TAY = 6'd23;
    localparam mode_t OP_TXA = 6'd24;
    localparam mode_t OP_TYA = 6'd25;
    localparam mode_t OP_TSX = 6'd26;
    localparam mode_t OP_TXS = 6'd27;
    localparam mode_t OP_CLC = 6'd28;
    localparam mode_t OP_SEC = 6'd29;
    localparam mode_t OP_CLI = 6'd30;
    localparam mode_t OP_SEI = 6'd31;
    localparam mode_t OP_CLD = 6'd32;
    localparam mode_t OP_SED = 6'd33;
    localparam mode_t OP_CLV = 6'd34;
    localparam mode_t OP_BRT = 6'd35;

    // Branch flag selector (branch_condition[2:1])
    localparam logic [1:0] BR_SEL_N = 2'd0;
    localparam logic [1:0] BR_SEL_V = 2'd1;
    localparam logic [1:0] BR_SEL_C = 2'd2;
    localparam logic [1:0] BR_SEL_Z = 2'd3;

    // Status bit positions: N V 1 B D I Z C
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam byte_t SP_RESET     = 8'hFF;
    localparam byte_t STATUS_RESET = 8'b0010_0000;

    // Update Z and N from a result byte
    function automatic byte_t set_zn(input byte_t status, input byte_t value);
        byte_t s;
        s = status;
        s[FLAG_Z] = (value == '0);
        s[FLAG_N] = value[ByteW-1];
        return s;
    endfunction

endpackage

[hdl/cpu8_alu_flag_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_flag_execute
// Execute unit of an 8-bit 6502-style core: A, X, Y, SP and status registers,
// binary ALU, compares, shifts, loads/transfers, flag ops and branch tests.
// ----------------------------------------------------------------------------
// One beat in, one beat out. An accepted beat lands in the input register;
// once the result register is free or being drained, the ALU evaluates it
// against the architectural registers, updates them and loads the result
// register. Throughput is one beat per cycle while results are drained: the
// ALU update of A/X/Y/SP/status feeds the following beat directly. The result
// register decouples the sides, so a new beat is taken into an empty input
// register while an unread result waits. Reset: A = X = Y = 0, SP = 0xFF,
// status = 0x20. Decimal mode is a stored flag only; ADC/SBC are always
// binary. Undefined mode codes leave A, X, Y, SP and status unchanged.
// ----------------------------------------------------------------------------
module cpu8_alu_flag_execute
    import cpu8alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] operand, [8] on_accumulator,
                                        // [11:9] branch_condition, [15:12] zero
    input  logic [5:0]  s_axis_tuser,   // [5:0] mode
    // Result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [7:0] acc_out, [15:8] x_out,
                                        // [23:16] y_out, [31:24] sp_out,
                                        // [39:32] status_out, [47:40] mem_value,
                                        // [48] mem_write, [49] branch_taken,
                                        // [55:50] zero
);

    // Input register
    logic        in_valid_reg;
    mode_t       in_mode_reg;
    byte_t       in_operand_reg;
    logic        in_on_acc_reg;
    logic [2:0]  in_cond_reg;

    // Architectural registers
    byte_t acc_reg, acc_next;
    byte_t x_reg, x_next;
    byte_t y_reg, y_next;
    byte_t sp_reg, sp_next;
    byte_t status_reg, status_next;

    // Result register
    logic  out_valid_reg;
    byte_t memv_reg, memv_next;
    logic  memw_reg, memw_next;
    logic  taken_reg, taken_next;

    logic advance;

    // ALU intermediates
    byte_t       add_m;
    logic [8:0]  add_sum;
    byte_t       cmp_reg;
    logic [8:0]  cmp_diff;
    byte_t       sh_in;
    byte_t       sh_out;
    logic        sh_carry;
    logic        br_flag;

    // The compute stage moves whenever the result register is free or drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg    <= s_axis_tuser;
            in_operand_reg <= s_axis_tdata[7:0];
            in_on_acc_reg  <= s_axis_tdata[8];
            in_cond_reg    <= s_axis_tdata[11:9];
        end
    end

    // Shared adder: ADC adds operand, SBC adds its complement
    assign add_m   = (in_mode_reg == OP_SBC) ? ~in_operand_reg : in_operand_reg;
    assign add_sum = {1'b0, acc_reg} + {1'b0, add_m} + {8'd0, status_reg[FLAG_C]};

    // Shared comparator
    always_comb
    begin
        unique case (in_mode_reg)
            OP_CPX:  cmp_reg = x_reg;
            OP_CPY:  cmp_reg = y_reg;
            default: cmp_reg = acc_reg;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, in_operand_reg};

    // Shifter / rotator
    assign sh_in = in_on_acc_reg ? acc_reg : in_operand_reg;
    always_comb
    begin
        unique case (in_mode_reg)
            OP_ASL:
            begin
                sh_out   = {sh_in[6:0], 1'b0};
                sh_carry = sh_in[7];
            end
            OP_ROL:
            begin
                sh_out   = {sh_in[6:0], status_reg[FLAG_C]};
                sh_carry = sh_in[7];
            end
            OP_ROR:
            begin
                sh_out   = {status_reg[FLAG_C], sh_in[7:1]};
                sh_carry = sh_in[0];
            end
            default:
            begin
                sh_out   = {1'b0, sh_in[7:1]};
                sh_carry = sh_in[0];
            end
        endcase
    end

    // Branch flag pick
    always_comb
    begin
        unique case (in_cond_reg[2:1])
            BR_SEL_N: br_flag = status_reg[FLAG_N];
            BR_SEL_V: br_flag = status_reg[FLAG_V];
            BR_SEL_C: br_flag = status_reg[FLAG_C];
            BR_SEL_Z: br_flag = status_reg[FLAG_Z];
            default:  br_flag = 1'b0;
        endcase
    end

    // Operation decode
    always_comb
    begin
        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        memv_next   = '0;
        memw_next   = 1'b0;
        taken_next  = 1'b0;

        unique case (in_mode_reg)
            OP_ADC, OP_SBC:
            begin
                acc_next            = add_sum[7:0];
                status_next         = set_zn(status_reg, add_sum[7:0]);
                status_next[FLAG_C] = add_sum[8];
                status_next[FLAG_V] = ~(acc_reg[7] ^ add_m[7]) & (acc_reg[7] ^ add_sum[7]);
            end
            OP_AND:
            begin
                acc_next    = acc_reg & in_operand_reg;
                status_next = set_zn(status_reg, acc_reg & in_operand_reg);
            end
            OP_ORA:
            begin
                acc_next    = acc_reg | in_operand_reg;
                status_next = set_zn(status_reg, acc_reg | in_operand_reg);
            end
            OP_EOR:
            begin
                acc_next    = acc_reg ^ in_operand_reg;
                status_next = set_zn(status_reg, acc_reg ^ in_operand_reg);
            end
            OP_CMP, OP_CPX, OP_CPY:
            begin
                status_next[FLAG_C] = !cmp_diff[8];
                status_next[FLAG_Z] = (cmp_reg == in_operand_reg);
                status_next[FLAG_N] = cmp_diff[7];
            end
            OP_BIT:
            begin
                status_next[FLAG_Z] = ((acc_reg & in_operand_reg) == '0);
                status_next[FLAG_N] = in_operand_reg[7];
                status_next[FLAG_V] = in_operand_reg[6];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                status_next         = set_zn(status_reg, sh_out);
                status_next[FLAG_C] = sh_carry;
                if (in_on_acc_reg)
                begin
                    acc_next = sh_out;
                end
                else
                begin
                    memv_next = sh_out;
                    memw_next = 1'b1;
                end
            end
            OP_INC:
            begin
                memv_next   = in_operand_reg + 8'd1;
                memw_next   = 1'b1;
                status_next = set_zn(status_reg, in_operand_reg + 8'd1);
            end
            OP_DEC:
            begin
                memv_next   = in_operand_reg - 8'd1;
                memw_next   = 1'b1;
                status_next = set_zn(status_reg, in_operand_reg - 8'd1);
            end
            OP_INX:
            begin
                x_next      = x_reg + 8'd1;
                status_next = set_zn(status_reg, x_reg + 8'd1);
            end
            OP_INY:
            begin
                y_next      = y_reg + 8'd1;
                status_next = set_zn(status_reg, y_reg + 8'd1);
            end
            OP_DEX:
            begin
                x_next      = x_reg - 8'd1;
                status_next = set_zn(status_reg, x_reg - 8'd1);
            end
            OP_DEY:
            begin
                y_next      = y_reg - 8'd1;
                status_next = set_zn(status_reg, y_reg - 8'd1);
            end
            OP_LDA:
            begin
                acc_next    = in_operand_reg;
                status_next = set_zn(status_reg, in_operand_reg);
            end
            OP_LDX:
            begin
                x_next      = in_operand_reg;
                status_next = set_zn(status_reg, in_operand_reg);
            end
            OP_LDY:
            begin
                y_next      = in_operand_reg;
                status_next = set_zn(status_reg, in_operand_reg);
            end
            OP_TAX:
            begin
                x_next      = acc_reg;
                status_next = set_zn(status_reg, acc_reg);
            end
            OP_TAY:
            begin
                y_next      = acc_reg;
                status_next = set_zn(status_reg, acc_reg);
            end
            OP_TXA:
            begin
                acc_next    = x_reg;
                status_next = set_zn(status_reg, x_reg);
            end
            OP_TYA:
            begin
                acc_next    = y_reg;
                status_next = set_zn(status_reg, y_reg);
            end
            OP_TSX:
            begin
                x_next      = sp_reg;
                status_next = set_zn(status_reg, sp_reg);
            end
            OP_TXS: sp_next = x_reg;   // no flags
            OP_CLC: status_next[FLAG_C] = 1'b0;
            OP_SEC: status_next[FLAG_C] = 1'b1;
            OP_CLI: status_next[FLAG_I] = 1'b0;
            OP_SEI: status_next[FLAG_I] = 1'b1;
            OP_CLD: status_next[FLAG_D] = 1'b0;
            OP_SED: status_next[FLAG_D] = 1'b1;
            OP_CLV: status_next[FLAG_V] = 1'b0;
            OP_BRT: taken_next = (br_flag == in_cond_reg[0]);
            default: ;   // undefined codes: no change
        endcase
    end

    // Architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            sp_reg     <= SP_RESET;
            status_reg <= STATUS_RESET;
        end
        else if (advance)
        begin
            acc_reg    <= acc_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            memv_reg  <= memv_next;
            memw_reg  <= memw_next;
            taken_reg <= taken_next;
        end
    end

    // Registers after the step are the architectural registers themselves
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, taken_reg, memw_reg, memv_reg,
                            status_reg, sp_reg, y_reg, x_reg, acc_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[FLAG_U] && !status_reg[FLAG_B])
        else $error("fixed status bits changed");

    a_memv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !memw_reg |-> memv_reg == '0)
        else $error("mem_value nonzero without mem_write");

    a_branch_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_mode_reg == OP_BRT |=>
            $stable(acc_reg) && $stable(x_reg) && $stable(y_reg)
            && $stable(sp_reg) && $stable(status_reg))
        else $error("branch test changed a register");

    a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_reg) && $stable(status_reg))
        else $error("registers changed without an executed beat");

endmodule
